// ===== rtl/tmrbank_pkg.sv =====
// Package for the timer bank: operation codes, result codes, the command
// beat that travels from the front end to the execution unit.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package tmrbank_pkg;

  localparam int OP_W   = 3;
  localparam int SLOT_W = 4;
  localparam int INT_W  = 31;
  localparam int EV_W   = 2;
  localparam int STS_W  = 2;

  localparam logic [OP_W-1:0] OP_TICK       = 3'd0;
  localparam logic [OP_W-1:0] OP_START_ONE  = 3'd1;
  localparam logic [OP_W-1:0] OP_START_PER  = 3'd2;
  localparam logic [OP_W-1:0] OP_RESTART    = 3'd3;
  localparam logic [OP_W-1:0] OP_CANCEL     = 3'd4;
  localparam logic [OP_W-1:0] OP_CANCEL_ALL = 3'd5;

  localparam logic [EV_W-1:0] EV_EXPIRED = 2'd0;
  localparam logic [EV_W-1:0] EV_CREATED = 2'd1;
  localparam logic [EV_W-1:0] EV_ACK     = 2'd2;

  localparam logic [STS_W-1:0] STS_OK       = 2'd0;
  localparam logic [STS_W-1:0] STS_FULL     = 2'd1;
  localparam logic [STS_W-1:0] STS_INACTIVE = 2'd2;

  localparam int MAX_RES = 16;
  localparam int CNT_W   = 5;

  localparam int QDEPTH = 2;
  localparam int QCNT_W = 2;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic              slot_ok;
    logic [INT_W-1:0]  interval;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/tmrbank_front.sv =====
// Front end of the timer bank: accepts input beats, drops unknown operations,
// range-checks the slot and queues commands in a two-entry FIFO.
// Depends on tmrbank_pkg.
`default_nettype none

module tmrbank_front #(
  parameter int SLOT_COUNT = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_ready,
  input  wire logic [tmrbank_pkg::OP_W-1:0]   in_operation,
  input  wire logic [tmrbank_pkg::SLOT_W-1:0] in_slot,
  input  wire logic [tmrbank_pkg::INT_W-1:0]  in_interval_ms,
  output logic                              q_valid,
  output tmrbank_pkg::cmd_t                 q_cmd,
  input  wire logic                         q_pop
);
  import tmrbank_pkg::*;

  localparam logic [8:0] SC = 9'(SLOT_COUNT);

  cmd_t              q_mem_r [QDEPTH];
  logic              wptr_r, wptr_nxt;
  logic              rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;
  logic              known_op;
  logic              push;
  cmd_t              push_cmd;

  always_comb begin
    known_op = (in_operation == OP_TICK) || (in_operation == OP_START_ONE) ||
               (in_operation == OP_START_PER) || (in_operation == OP_RESTART) ||
               (in_operation == OP_CANCEL) || (in_operation == OP_CANCEL_ALL);
    push_cmd.op       = in_operation;
    push_cmd.slot     = in_slot;
    push_cmd.slot_ok  = ({5'd0, in_slot} < SC);
    push_cmd.interval = in_interval_ms;
  end

  assign in_ready = (cnt_r != QCNT_W'(QDEPTH));
  assign push     = in_valid && in_ready && known_op;
  assign q_valid  = (cnt_r != '0);
  assign q_cmd    = q_mem_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? ~wptr_r : wptr_r;
    rptr_nxt = q_pop ? ~rptr_r : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !q_pop) begin
      cnt_nxt = cnt_r + QCNT_W'(1);
    end else if (!push && q_pop) begin
      cnt_nxt = cnt_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wptr_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/tmrbank_back.sv =====
// Execution unit of the timer bank: slot flags, interval and start-time
// memories, the millisecond counter, the tick scan and the result register.
// Depends on tmrbank_pkg.
`default_nettype none

module tmrbank_back #(
  parameter int SLOT_COUNT = 16,
  parameter int TIME_BITS  = 32
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         q_valid,
  input  wire tmrbank_pkg::cmd_t            q_cmd,
  output logic                              q_pop,
  input  wire logic                         out_ready,
  output logic                              out_valid,
  output logic [tmrbank_pkg::EV_W-1:0]      out_event_res,
  output logic [tmrbank_pkg::SLOT_W-1:0]    out_slot_id,
  output logic [tmrbank_pkg::STS_W-1:0]     out_status,
  output logic                              out_was_periodic,
  output logic                              out_last
);
  import tmrbank_pkg::*;

  localparam int SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CW = (TIME_BITS > INT_W) ? TIME_BITS : INT_W;
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOT_COUNT - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_ALLOC = 2'd2;
  localparam logic [1:0] ST_FLUSH = 2'd3;

  logic [1:0]            state_r, state_nxt;
  logic [SW-1:0]         idx_r, idx_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [TIME_BITS-1:0]  now_r, now_nxt;
  logic [SLOT_COUNT-1:0] act_r, act_nxt;
  logic [SLOT_COUNT-1:0] per_r, per_nxt;
  logic                  pend_v_r, pend_v_nxt;
  logic [SLOT_W-1:0]     pend_id_r, pend_id_nxt;
  logic                  pend_per_r, pend_per_nxt;
  logic                  alloc_per_r, alloc_per_nxt;
  logic [INT_W-1:0]      alloc_int_r, alloc_int_nxt;

  logic                  out_valid_r, out_valid_nxt;
  logic [EV_W-1:0]       out_ev_r, out_ev_nxt;
  logic [SLOT_W-1:0]     out_id_r, out_id_nxt;
  logic [STS_W-1:0]      out_sts_r, out_sts_nxt;
  logic                  out_per_r, out_per_nxt;
  logic                  out_last_r, out_last_nxt;

  logic [INT_W-1:0]      int_mem [SLOT_COUNT];
  logic [TIME_BITS-1:0]  start_mem [SLOT_COUNT];
  logic [INT_W-1:0]      rd_int_r;
  logic [TIME_BITS-1:0]  rd_start_r;
  logic                  rd_en;
  logic [SW-1:0]         rd_addr;
  logic                  st_we;
  logic                  it_we;
  logic [SW-1:0]         wa;

  logic                  out_free;
  logic [SW-1:0]         cmd_idx;
  logic                  cmd_hit;
  logic [TIME_BITS-1:0]  elapsed;
  logic                  hit;
  logic                  scan_done;

  function automatic logic [SLOT_W-1:0] id_of(input logic [SW-1:0] i);
    logic [SW+SLOT_W-1:0] e;
    e = {{SLOT_W{1'b0}}, i};
    return e[SLOT_W-1:0];
  endfunction

  function automatic logic [SW-1:0] idx_of(input logic [SLOT_W-1:0] s);
    logic [SW+SLOT_W-1:0] e;
    e = {{SW{1'b0}}, s};
    return e[SW-1:0];
  endfunction

  always_comb begin
    out_free  = !out_valid_r || out_ready;
    cmd_idx   = idx_of(q_cmd.slot);
    cmd_hit   = q_cmd.slot_ok && act_r[cmd_idx];
    elapsed   = now_r - rd_start_r;
    hit       = act_r[idx_r] && (CW'(elapsed) >= CW'(rd_int_r));
    scan_done = (idx_r == LAST_SLOT) || (hit && (cnt_r == CNT_W'(MAX_RES - 1)));
  end

  always_comb begin
    state_nxt     = state_r;
    idx_nxt       = idx_r;
    cnt_nxt       = cnt_r;
    now_nxt       = now_r;
    act_nxt       = act_r;
    per_nxt       = per_r;
    pend_v_nxt    = pend_v_r;
    pend_id_nxt   = pend_id_r;
    pend_per_nxt  = pend_per_r;
    alloc_per_nxt = alloc_per_r;
    alloc_int_nxt = alloc_int_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_ev_nxt    = out_ev_r;
    out_id_nxt    = out_id_r;
    out_sts_nxt   = out_sts_r;
    out_per_nxt   = out_per_r;
    out_last_nxt  = out_last_r;
    q_pop         = 1'b0;
    rd_en         = 1'b0;
    rd_addr       = idx_r;
    st_we         = 1'b0;
    it_we         = 1'b0;
    wa            = idx_r;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          unique case (q_cmd.op)
            OP_TICK: begin
              q_pop     = 1'b1;
              now_nxt   = now_r + TIME_BITS'(1);
              idx_nxt   = '0;
              cnt_nxt   = '0;
              rd_en     = 1'b1;
              rd_addr   = '0;
              state_nxt = ST_SCAN;
            end
            OP_START_ONE, OP_START_PER: begin
              q_pop         = 1'b1;
              alloc_per_nxt = (q_cmd.op == OP_START_PER);
              alloc_int_nxt = q_cmd.interval;
              idx_nxt       = '0;
              state_nxt     = ST_ALLOC;
            end
            OP_RESTART, OP_CANCEL: begin
              if (out_free) begin
                q_pop         = 1'b1;
                out_valid_nxt = 1'b1;
                out_ev_nxt    = EV_ACK;
                out_id_nxt    = q_cmd.slot;
                out_sts_nxt   = cmd_hit ? STS_OK : STS_INACTIVE;
                out_per_nxt   = 1'b0;
                out_last_nxt  = 1'b1;
                if (cmd_hit) begin
                  if (q_cmd.op == OP_RESTART) begin
                    st_we = 1'b1;
                    wa    = cmd_idx;
                  end else begin
                    act_nxt[cmd_idx] = 1'b0;
                  end
                end
              end
            end
            OP_CANCEL_ALL: begin
              if (out_free) begin
                q_pop         = 1'b1;
                act_nxt       = '0;
                out_valid_nxt = 1'b1;
                out_ev_nxt    = EV_ACK;
                out_id_nxt    = '0;
                out_sts_nxt   = STS_OK;
                out_per_nxt   = 1'b0;
                out_last_nxt  = 1'b1;
              end
            end
            default: begin
              q_pop = 1'b1;
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (!(hit && pend_v_r && !out_free)) begin
          if (hit) begin
            if (pend_v_r) begin
              out_valid_nxt = 1'b1;
              out_ev_nxt    = EV_EXPIRED;
              out_id_nxt    = pend_id_r;
              out_sts_nxt   = STS_OK;
              out_per_nxt   = pend_per_r;
              out_last_nxt  = 1'b0;
            end
            pend_v_nxt   = 1'b1;
            pend_id_nxt  = id_of(idx_r);
            pend_per_nxt = per_r[idx_r];
            cnt_nxt      = cnt_r + CNT_W'(1);
            if (per_r[idx_r]) begin
              st_we = 1'b1;
              wa    = idx_r;
            end else begin
              act_nxt[idx_r] = 1'b0;
            end
          end
          if (scan_done) begin
            state_nxt = ST_FLUSH;
          end else begin
            idx_nxt = idx_r + SW'(1);
            rd_en   = 1'b1;
            rd_addr = idx_r + SW'(1);
          end
        end
      end
      ST_ALLOC: begin
        if (!act_r[idx_r]) begin
          if (out_free) begin
            act_nxt[idx_r] = 1'b1;
            per_nxt[idx_r] = alloc_per_r;
            st_we          = 1'b1;
            it_we          = 1'b1;
            wa             = idx_r;
            out_valid_nxt  = 1'b1;
            out_ev_nxt     = EV_CREATED;
            out_id_nxt     = id_of(idx_r);
            out_sts_nxt    = STS_OK;
            out_per_nxt    = 1'b0;
            out_last_nxt   = 1'b1;
            state_nxt      = ST_IDLE;
          end
        end else if (idx_r == LAST_SLOT) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_ev_nxt    = EV_CREATED;
            out_id_nxt    = '0;
            out_sts_nxt   = STS_FULL;
            out_per_nxt   = 1'b0;
            out_last_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end else begin
          idx_nxt = idx_r + SW'(1);
        end
      end
      ST_FLUSH: begin
        if (!pend_v_r) begin
          state_nxt = ST_IDLE;
        end else if (out_free) begin
          out_valid_nxt = 1'b1;
          out_ev_nxt    = EV_EXPIRED;
          out_id_nxt    = pend_id_r;
          out_sts_nxt   = STS_OK;
          out_per_nxt   = pend_per_r;
          out_last_nxt  = 1'b1;
          pend_v_nxt    = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (it_we) begin
      int_mem[wa] <= alloc_int_r;
    end
    if (st_we) begin
      start_mem[wa] <= now_r;
    end
    if (rd_en) begin
      rd_int_r   <= int_mem[rd_addr];
      rd_start_r <= start_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    pend_id_r   <= pend_id_nxt;
    pend_per_r  <= pend_per_nxt;
    alloc_per_r <= alloc_per_nxt;
    alloc_int_r <= alloc_int_nxt;
    out_ev_r    <= out_ev_nxt;
    out_id_r    <= out_id_nxt;
    out_sts_r   <= out_sts_nxt;
    out_per_r   <= out_per_nxt;
    out_last_r  <= out_last_nxt;
    idx_r       <= idx_nxt;
    cnt_r       <= cnt_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      now_r       <= '0;
      act_r       <= '0;
      per_r       <= '0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      now_r       <= now_nxt;
      act_r       <= act_nxt;
      per_r       <= per_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_event_res    = out_ev_r;
  assign out_slot_id      = out_id_r;
  assign out_status       = out_sts_r;
  assign out_was_periodic = out_per_r;
  assign out_last         = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (cnt_r < CNT_W'(MAX_RES)))
    else $error("expiry count passed the per-tick limit");

  a_pend_state: assert property (@(posedge clk) disable iff (!rst_n)
    pend_v_r |-> ((state_r == ST_SCAN) || (state_r == ST_FLUSH)))
    else $error("held expiry outside a tick scan");

  a_tick_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && q_valid && q_cmd.op == OP_TICK)
      |=> (now_r == $past(now_r) + TIME_BITS'(1)))
    else $error("millisecond counter did not advance on a tick");

  a_scan_leaves_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_FLUSH && !pend_v_r) |=> (state_r == ST_IDLE))
    else $error("scan without expiries did not return to idle");

endmodule

`default_nettype wire

// ===== rtl/one_shot_periodic_timer_bank_top.sv =====
// Bank of one-shot and periodic timer slots with its own millisecond counter.
// Input beats carry an operation; each operation gives zero or more result beats.
// The end of a beat's results is marked by out_last.
// Channels: in_* and out_* use valid/ready; a beat moves when both are high.
// Operations: tick, start one-shot, start periodic, restart, cancel, cancel all.
// Codes 6 and 7 are taken and dropped without a result.
// A two-entry command FIFO sits in front of the unit.
// A tick scans one slot a cycle unless an expiry waits for the result register.
// A start searches the slot flags one a cycle and takes the lowest free slot.
// Restart, cancel and cancel all act at the FIFO head; the result is registered.
// A tick gives at most 16 expiry beats in slot order; later slots fire later.
// Reset (rst_n low at a clock edge) clears the counter and frees every slot.
// When out_ready is low the result register holds its beat; a further beat waits.
// The FIFO keeps taking input beats until it fills.
// Depends on tmrbank_pkg, tmrbank_front and tmrbank_back.
`default_nettype none

module one_shot_periodic_timer_bank_top #(
  parameter int SLOT_COUNT = 16,
  parameter int TIME_BITS  = 32
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [tmrbank_pkg::OP_W-1:0]   in_operation,
  input  wire logic [tmrbank_pkg::SLOT_W-1:0] in_slot,
  input  wire logic [tmrbank_pkg::INT_W-1:0]  in_interval_ms,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [tmrbank_pkg::EV_W-1:0]        out_event_res,
  output logic [tmrbank_pkg::SLOT_W-1:0]      out_slot_id,
  output logic [tmrbank_pkg::STS_W-1:0]       out_status,
  output logic                                out_was_periodic,
  output logic                                out_last
);
  import tmrbank_pkg::*;

  logic q_valid;
  logic q_pop;
  cmd_t q_cmd;

  tmrbank_front #(
    .SLOT_COUNT(SLOT_COUNT)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_operation  (in_operation),
    .in_slot       (in_slot),
    .in_interval_ms(in_interval_ms),
    .q_valid       (q_valid),
    .q_cmd         (q_cmd),
    .q_pop         (q_pop)
  );

  tmrbank_back #(
    .SLOT_COUNT(SLOT_COUNT),
    .TIME_BITS (TIME_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_cmd           (q_cmd),
    .q_pop           (q_pop),
    .out_ready       (out_ready),
    .out_valid       (out_valid),
    .out_event_res   (out_event_res),
    .out_slot_id     (out_slot_id),
    .out_status      (out_status),
    .out_was_periodic(out_was_periodic),
    .out_last        (out_last)
  );

endmodule

`default_nettype wire

// ===== test/one_shot_periodic_timer_bank_top_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for one_shot_periodic_timer_bank_top: random valid/ready
// traffic on both channels, checked beat by beat against a scoreboard predictor.
// Depends on tmrbank_pkg and the timer bank RTL.

module one_shot_periodic_timer_bank_top_tb;
  import tmrbank_pkg::*;

  localparam int SLOT_COUNT = 16;
  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;
  localparam int RANDOM_COMMANDS = 90;
  localparam logic [OP_W-1:0] OP_RSVD_6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD_7 = 3'd7;

  typedef struct packed {
    logic [EV_W-1:0]   ev;
    logic [SLOT_W-1:0] slot;
    logic [STS_W-1:0]  status;
    logic              per;
    logic              last;
  } timer_event_t;

  class timer_bank_scoreboard;
    logic [31:0]      now_ms;
    logic [15:0]      active;
    logic [15:0]      periodic;
    logic [INT_W-1:0] interval [SLOT_COUNT];
    logic [31:0]      started [SLOT_COUNT];
    timer_event_t     pending_events [$];
    int mismatches;
    int commands;
    int beats;
    int expiries;
    int full_hits;

    function new();
      now_ms = '0;
      active = '0;
      periodic = '0;
      mismatches = 0;
      commands = 0;
      beats = 0;
      expiries = 0;
      full_hits = 0;
    endfunction

    function void note_command(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                               input logic [INT_W-1:0] iv);
      timer_event_t batch [$];
      timer_event_t ev;
      int free_idx;
      free_idx = -1;
      ev = '0;
      commands++;
      case (op)
        OP_TICK: begin
          now_ms = now_ms + 32'd1;
          for (int i = 0; i < SLOT_COUNT && batch.size() < MAX_RES; i++) begin
            if (active[i] && (now_ms - started[i]) >= {1'b0, interval[i]}) begin
              ev = '0;
              ev.ev = EV_EXPIRED;
              ev.slot = SLOT_W'(i);
              ev.status = STS_OK;
              if (periodic[i]) begin
                started[i] = now_ms;
                ev.per = 1'b1;
              end else begin
                active[i] = 1'b0;
              end
              batch.insert(batch.size(), ev);
            end
          end
        end
        OP_START_ONE, OP_START_PER: begin
          for (int i = 0; i < SLOT_COUNT; i++) begin
            if (free_idx < 0 && !active[i]) free_idx = i;
          end
          ev.ev = EV_CREATED;
          if (free_idx >= 0) begin
            active[free_idx] = 1'b1;
            periodic[free_idx] = (op == OP_START_PER);
            interval[free_idx] = iv;
            started[free_idx] = now_ms;
            ev.slot = SLOT_W'(free_idx);
            ev.status = STS_OK;
          end else begin
            ev.slot = '0;
            ev.status = STS_FULL;
          end
          batch.insert(batch.size(), ev);
        end
        OP_RESTART, OP_CANCEL: begin
          ev.ev = EV_ACK;
          ev.slot = slot;
          if (active[slot]) begin
            if (op == OP_RESTART) started[slot] = now_ms;
            else active[slot] = 1'b0;
            ev.status = STS_OK;
          end else begin
            ev.status = STS_INACTIVE;
          end
          batch.insert(batch.size(), ev);
        end
        OP_CANCEL_ALL: begin
          active = '0;
          ev.ev = EV_ACK;
          ev.slot = '0;
          ev.status = STS_OK;
          batch.insert(batch.size(), ev);
        end
        default: begin
        end
      endcase
      if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
      foreach (batch[k]) pending_events.insert(pending_events.size(), batch[k]);
    endfunction

    task report_mismatch(input string field, input logic [31:0] got, input logic [31:0] want);
      mismatches++;
      $display("%0t: mismatch on %s at result beat %0d: got %0d, expected %0d",
               $time, field, beats, got, want);
    endtask

    task check_event(input timer_event_t got);
      timer_event_t want;
      beats++;
      if (got.ev == EV_EXPIRED) expiries++;
      if (got.status == STS_FULL) full_hits++;
      if (pending_events.size() == 0) begin
        report_mismatch("unexpected beat", 32'(got), 32'd0);
        return;
      end
      want = pending_events.pop_front();
      if (got.ev != want.ev) report_mismatch("event_res", 32'(got.ev), 32'(want.ev));
      if (got.slot != want.slot) report_mismatch("slot_id", 32'(got.slot), 32'(want.slot));
      if (got.status != want.status)
        report_mismatch("status", 32'(got.status), 32'(want.status));
      if (got.per != want.per) report_mismatch("was_periodic", 32'(got.per), 32'(want.per));
      if (got.last != want.last) report_mismatch("last", 32'(got.last), 32'(want.last));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [OP_W-1:0] in_operation = OP_TICK;
  logic [SLOT_W-1:0] in_slot = '0;
  logic [INT_W-1:0] in_interval_ms = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [EV_W-1:0] out_event_res;
  logic [SLOT_W-1:0] out_slot_id;
  logic [STS_W-1:0] out_status;
  logic out_was_periodic;
  logic out_last;

  timer_bank_scoreboard sb = new();
  int ready_hold = 0;
  logic ready_level = 1'b0;
  int sink_roll;
  int idle_cycles = 0;

  one_shot_periodic_timer_bank_top #(
    .SLOT_COUNT(SLOT_COUNT),
    .TIME_BITS(32)
  ) dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_operation(in_operation),
    .in_slot(in_slot),
    .in_interval_ms(in_interval_ms),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_event_res(out_event_res),
    .out_slot_id(out_slot_id),
    .out_status(out_status),
    .out_was_periodic(out_was_periodic),
    .out_last(out_last)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      sb.check_event({out_event_res, out_slot_id, out_status, out_was_periodic, out_last});
    end
    if (ready_hold == 0) begin
      sink_roll = $urandom_range(0, 99);
      if (sink_roll < 60) begin
        ready_level = 1'b1;
        ready_hold = $urandom_range(1, 20);
      end else if (sink_roll < 90) begin
        ready_level = 1'b0;
        ready_hold = $urandom_range(1, 3);
      end else begin
        ready_level = 1'b0;
        ready_hold = $urandom_range(10, 40);
      end
    end
    ready_hold = ready_hold - 1;
    out_ready <= ready_level;
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no beat moved for %0d cycles, %0d results still pending",
               $time, IDLE_LIMIT, sb.pending_events.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_command(input logic [OP_W-1:0] op, input logic [SLOT_W-1:0] slot,
                              input logic [INT_W-1:0] iv);
    int gap;
    int roll;
    roll = $urandom_range(0, 99);
    gap = (roll < 55) ? 0 : (roll < 90) ? $urandom_range(1, 3) : $urandom_range(8, 30);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_slot <= slot;
    in_interval_ms <= iv;
    do @(posedge clk); while (!in_ready);
    sb.note_command(op, slot, iv);
  endtask

  initial begin
    int issued;
    int roll;
    logic [OP_W-1:0] op;
    logic [SLOT_W-1:0] slot;
    logic [INT_W-1:0] iv;
    issued = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    send_command(OP_TICK, 4'd0, 31'd0);
    send_command(OP_RESTART, 4'd3, 31'd0);
    send_command(OP_CANCEL, 4'd15, 31'h7FFF_FFFF);
    send_command(OP_RSVD_6, 4'hF, 31'h7FFF_FFFF);
    send_command(OP_RSVD_7, 4'd0, 31'd0);
    for (int i = 0; i < SLOT_COUNT - 1; i++) begin
      send_command(i[0] ? OP_START_PER : OP_START_ONE, SLOT_W'(i), INT_W'(i % 2));
    end
    send_command(OP_START_PER, 4'd0, 31'h7FFF_FFFF);
    send_command(OP_START_ONE, 4'd0, 31'd5);
    send_command(OP_TICK, 4'd0, 31'd0);
    send_command(OP_RESTART, 4'd15, 31'd0);
    send_command(OP_CANCEL, 4'd15, 31'd0);
    send_command(OP_TICK, 4'd0, 31'd0);
    send_command(OP_CANCEL_ALL, 4'd0, 31'd0);

    while (issued < RANDOM_COMMANDS) begin
      roll = $urandom_range(0, 99);
      slot = SLOT_W'($urandom_range(0, 15));
      iv = ($urandom_range(0, 99) < 85) ? INT_W'($urandom_range(0, 6)) : INT_W'($urandom);
      if (roll < 40) op = OP_TICK;
      else if (roll < 55) op = OP_START_ONE;
      else if (roll < 70) op = OP_START_PER;
      else if (roll < 80) op = OP_RESTART;
      else if (roll < 90) op = OP_CANCEL;
      else if (roll < 93) op = OP_CANCEL_ALL;
      else if (roll < 96) op = OP_RSVD_6;
      else op = OP_RSVD_7;
      send_command(op, slot, iv);
      if (op != OP_RSVD_6 && op != OP_RSVD_7) issued++;
    end
    in_valid <= 1'b0;

    while (sb.pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d commands and checked %0d result beats: %0d expiries, %0d bank-full.",
             sb.commands, sb.beats, sb.expiries, sb.full_hits);
    $display("Mismatches found: %0d.", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== one_shot_periodic_timer_bank_top.f =====
rtl/tmrbank_pkg.sv
rtl/tmrbank_front.sv
rtl/tmrbank_back.sv
rtl/one_shot_periodic_timer_bank_top.sv
test/one_shot_periodic_timer_bank_top_tb.sv
